@@ rtl/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Shared sizes, stack entry codes and bracket decode functions.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // Number of stack entries the checker can hold.
    localparam int STACK_DEPTH = 64;

    // The level counter must hold STACK_DEPTH itself; the address does not.
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28; // (
    localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29; // )
    localparam logic [CHAR_W-1:0] CHAR_LSQ    = 8'h5B; // [
    localparam logic [CHAR_W-1:0] CHAR_RSQ    = 8'h5D; // ]
    localparam logic [CHAR_W-1:0] CHAR_LCURL  = 8'h7B; // {
    localparam logic [CHAR_W-1:0] CHAR_RCURL  = 8'h7D; // }

    // Stack entry code. CODE_OTHER is a byte that no bracket can close.
    typedef enum logic [1:0] {
        CODE_OTHER  = 2'd0,
        CODE_PAREN  = 2'd1,
        CODE_SQUARE = 2'd2,
        CODE_CURLY  = 2'd3
    } t_code;

    localparam int CODE_W = $bits(t_code);

    // Code of the opening bracket that this byte would close.
    function automatic t_code closer_code(input logic [CHAR_W-1:0] c);
        t_code r;
        case (c)
            CHAR_RPAREN: r = CODE_PAREN;
            CHAR_RSQ:    r = CODE_SQUARE;
            CHAR_RCURL:  r = CODE_CURLY;
            default:     r = CODE_OTHER;
        endcase
        return r;
    endfunction

    // Code under which this byte is pushed.
    function automatic t_code push_code(input logic [CHAR_W-1:0] c);
        t_code r;
        case (c)
            CHAR_LPAREN: r = CODE_PAREN;
            CHAR_LSQ:    r = CODE_SQUARE;
            CHAR_LCURL:  r = CODE_CURLY;
            default:     r = CODE_OTHER;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/bbc_ram.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bracket_balance_checker_top.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker
// Streams a string one byte per item and reports whether its brackets balance.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | tdata (low bit up)             | tuser        | tlast
// ---------+-----------+--------------------------------+--------------+--------------
// s_axis   | in        | char_code[7:0]                 | char_present | end_of_string
// m_axis   | out       | is_balanced, stack_overflowed  | -            | -
//
// One item is taken every cycle unless a verdict waits unread in the output
// register; the stack update for a byte finishes in the cycle it is
// accepted, thanks to a top-of-stack register. The stack RAM is read ahead
// at the entry below the top, so a pop always finds its new top in the RAM
// read data. A verdict appears in the cycle after the item that ends the
// string and sits in an output register; the input keeps flowing while
// that register is empty or being drained. Reset is synchronous and needs
// no clearing pass: the stack RAM content is never trusted across strings.
//
module bracket_balance_checker_top
    import bbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,  // [7:0] char_code
    input  logic                  s_axis_tuser,  // [0] char_present
    input  logic                  s_axis_tlast,  // end_of_string

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata   // [0] is_balanced, [1] stack_overflowed
);

    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
    localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);
    localparam logic [LVL_W-1:0] LVL_TWO  = LVL_W'(2);
    localparam int               OUT_PAD_W = 6;

    // Stack state. r_top mirrors the entry at r_level-1 when r_level is not 0.
    logic [LVL_W-1:0] r_level, n_level;
    t_code            r_top,   n_top;
    logic             r_odd,   n_odd;
    logic             r_ovf,   n_ovf;

    // Output register.
    logic             r_out_valid;
    logic             r_out_bal;
    logic             r_out_ovf;

    logic              in_acc;
    t_code             want;
    t_code             pcode;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [LVL_W-1:0]  rd_lvl;
    logic [CODE_W-1:0] ram_rdata;
    logic              v_bal;
    logic              v_ovf;

    // A new item can go whenever the verdict slot is free or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign want  = closer_code(s_axis_tdata);
    assign pcode = push_code(s_axis_tdata);

    always_comb begin
        n_level   = r_level;
        n_top     = r_top;
        n_odd     = r_odd;
        n_ovf     = r_ovf;
        ram_we    = 1'b0;
        ram_waddr = r_level[ADDR_W-1:0];

        if (in_acc && s_axis_tuser) begin
            n_odd = ~r_odd;
            if (want != CODE_OTHER && r_level != '0 && r_top == want) begin
                // Pop: the entry below the top was prefetched last cycle.
                n_level = r_level - LVL_ONE;
                n_top   = t_code'(ram_rdata);
            end else if (r_level == LVL_FULL) begin
                n_ovf = 1'b1;
            end else begin
                ram_we  = 1'b1;
                n_level = r_level + LVL_ONE;
                n_top   = pcode;
            end
        end

        // Verdict reflects the state after this item's byte.
        v_bal = !n_odd && (n_level == '0) && !n_ovf;
        v_ovf = n_ovf;

        if (in_acc && s_axis_tlast) begin
            n_level = '0;
            n_odd   = 1'b0;
            n_ovf   = 1'b0;
        end

        // Prefetch the entry below the next top. A push writes index level
        // while this read targets level-1, so the two never collide; below
        // level 2 the read data is unused.
        rd_lvl    = n_level - LVL_TWO;
        ram_raddr = rd_lvl[ADDR_W-1:0];
    end

    bbc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (pcode),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_odd       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_level <= n_level;
            r_odd   <= n_odd;
            r_ovf   <= n_ovf;
            if (in_acc && s_axis_tlast) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (in_acc && s_axis_tlast) begin
            r_out_bal <= v_bal;
            r_out_ovf <= v_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_ovf, r_out_bal};

    // The level counter never runs past the stack depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_FULL)
        else $error("stack level beyond depth");

    // Overflow can only be recorded with a full stack.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_ovf && n_ovf) |-> (r_level == LVL_FULL))
        else $error("overflow flag without full stack");

    // Without overflow, every byte moved the level by one, so parities agree.
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovf |-> (r_odd == r_level[0]))
        else $error("length parity and stack level disagree");

    // A string end always produces a verdict in the next cycle.
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("missing verdict after end of string");

    // An overflowed string is never reported as balanced.
    a_ovf_not_bal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("overflowed string reported balanced");

endmodule

@@ sim/bracket_balance_checker_top_tb.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker testbench
// Streams byte strings into the checker and checks every verdict against an
// independent predictor of the bracket stack, under random flow control.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top_tb;
    import bbc_pkg::*;

    typedef logic [CHAR_W-1:0] t_char;

    // One verdict as it appears in the result item.
    typedef struct packed {
        logic       overflowed;
        logic       balanced;
    } t_verdict;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_SLOW
    } t_rx_mode;

    typedef enum int {
        STR_NESTED,
        STR_DAMAGED,
        STR_JUMBLE,
        STR_DEEP
    } t_str_kind;

    localparam int TARGET_ITEMS  = 750;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the bracket stack and keeps the verdicts still due.
    // ------------------------------------------------------------------------
    class verdict_scoreboard;
        t_code       stack_mem[STACK_DEPTH];
        int unsigned level;
        bit          odd_len;
        bit          overflowed;
        t_verdict    verdicts_due[$];
        int unsigned errors;

        function new();
            level      = 0;
            odd_len    = 0;
            overflowed = 0;
            errors     = 0;
        endfunction

        // Apply one accepted input item to the mirrored stack.
        function void take_item(t_char c, bit present, bit last);
            t_code    closes;
            t_code    opens;
            t_code    top;
            t_verdict v;
            if (present) begin
                closes = CODE_OTHER;
                opens  = CODE_OTHER;
                case (c)
                    CHAR_RPAREN: closes = CODE_PAREN;
                    CHAR_RSQ:    closes = CODE_SQUARE;
                    CHAR_RCURL:  closes = CODE_CURLY;
                    CHAR_LPAREN: opens  = CODE_PAREN;
                    CHAR_LSQ:    opens  = CODE_SQUARE;
                    CHAR_LCURL:  opens  = CODE_CURLY;
                    default: ;
                endcase
                odd_len = !odd_len;
                top = (level > 0) ? stack_mem[level-1] : CODE_OTHER;
                if (closes != CODE_OTHER && level > 0 && top == closes) begin
                    level--;
                end else if (level >= STACK_DEPTH) begin
                    overflowed = 1;
                end else begin
                    stack_mem[level] = opens;
                    level++;
                end
            end
            if (last) begin
                v.balanced   = !odd_len && level == 0 && !overflowed;
                v.overflowed = overflowed;
                verdicts_due.push_back(v);
                level      = 0;
                odd_len    = 0;
                overflowed = 0;
            end
        endfunction

        // Compare one accepted result item with the oldest verdict due.
        function void check_result(logic [7:0] data);
            t_verdict v;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %b", $time, data);
                errors++;
            end else begin
                v = verdicts_due.pop_front();
                if (data[0] !== v.balanced) begin
                    $display("%0t: is_balanced expected %0d actual %b",
                             $time, v.balanced, data[0]);
                    errors++;
                end
                if (data[1] !== v.overflowed) begin
                    $display("%0t: stack_overflowed expected %0d actual %b",
                             $time, v.overflowed, data[1]);
                    errors++;
                end
                if (data[7:2] !== 6'd0) begin
                    $display("%0t: tdata padding expected 0 actual %b", $time, data[7:2]);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block.
    // ------------------------------------------------------------------------
    logic  i_clk;
    logic  i_rst_n       = 1'b0;
    logic  s_axis_tvalid = 1'b0;
    logic  s_axis_tready;
    t_char s_axis_tdata  = '0;
    logic  s_axis_tuser  = 1'b0;
    logic  s_axis_tlast  = 1'b0;
    logic  m_axis_tvalid;
    logic  m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    bracket_balance_checker_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
        .s_axis_tuser  (s_axis_tuser),   // [0] char_present
        .s_axis_tlast  (s_axis_tlast),   // end_of_string
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [0] is_balanced, [1] stack_overflowed
    );

    verdict_scoreboard sb = new();

    // Both handshakes are sampled in one process, inputs first, so a verdict
    // can never be checked before the item that caused it has been noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog: the run is stuck if neither side moves an item for too long.
    int unsigned stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("bracket_balance_checker_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switches between random ready patterns, and once holds off
    // for a long stretch when the stimulus asks for it.
    // ------------------------------------------------------------------------
    logic        hold_req   = 1'b0;
    logic        hold_taken = 1'b0;
    int unsigned hold_left  = 0;
    t_rx_mode    rx_mode    = RX_OPEN;
    int unsigned mode_left  = 0;

    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;

    function automatic t_char opener_of(t_code k);
        case (k)
            CODE_PAREN:  return CHAR_LPAREN;
            CODE_SQUARE: return CHAR_LSQ;
            default:     return CHAR_LCURL;
        endcase
    endfunction

    function automatic t_char closer_of(t_code k);
        case (k)
            CODE_PAREN:  return CHAR_RPAREN;
            CODE_SQUARE: return CHAR_RSQ;
            default:     return CHAR_RCURL;
        endcase
    endfunction

    function automatic t_char any_bracket();
        t_code k;
        k = t_code'($urandom_range(1, 3));
        return $urandom_range(0, 1) ? opener_of(k) : closer_of(k);
    endfunction

    // Offer one item and hold it until it is accepted. Valid is lowered only
    // when a gap between bursts starts, so it never toggles within one step.
    task automatic send_item(input t_char code, input bit present, input bit last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (present || last)
            items_sent++;
    endtask

    // Send one string. Filler items without a byte are sprinkled in when
    // asked; the string ends either on its last byte or on an empty end item.
    task automatic send_string(input t_char str[$], input bit end_marker, input int fill_pct);
        for (int i = 0; i < str.size(); i++) begin
            if ($urandom_range(0, 99) < fill_pct)
                send_item(t_char'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(str[i], 1'b1, !end_marker && i == str.size() - 1);
        end
        if (end_marker || str.size() == 0)
            send_item(t_char'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Stop offering items until every verdict due has been taken.
    task automatic drain_verdicts();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // A correctly nested string of the given number of bracket pairs.
    task automatic build_nested(input int pairs, ref t_char str[$]);
        t_code open_q[$];
        t_code k;
        int    opens_left;
        opens_left = pairs;
        while (opens_left > 0 || open_q.size() > 0) begin
            if (opens_left > 0 && (open_q.size() == 0 || $urandom_range(0, 1))) begin
                k = t_code'($urandom_range(1, 3));
                open_q.push_back(k);
                str.push_back(opener_of(k));
                opens_left--;
            end else begin
                str.push_back(closer_of(open_q.pop_back()));
            end
        end
    endtask

    // Open to the given depth, then close everything again. Beyond the stack
    // depth this overflows; at exactly the depth it must still balance.
    task automatic build_deep(input int depth, ref t_char str[$]);
        t_code open_q[$];
        t_code k;
        for (int i = 0; i < depth; i++) begin
            k = t_code'($urandom_range(1, 3));
            open_q.push_back(k);
            str.push_back(opener_of(k));
        end
        while (open_q.size() > 0)
            str.push_back(closer_of(open_q.pop_back()));
    endtask

    initial begin
        t_char       str[$];
        t_str_kind   kind;
        int unsigned str_count;
        int unsigned pick;
        int unsigned pos;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings: empty strings back to back, each bracket pair,
        // a wrong closer, a closer on an empty stack, odd length, the byte
        // value zero, the all-ones byte, three kinds nested in each other, and a
        // filler item inside a string.
        str = {};
        send_string(str, 1'b1, 0);
        send_string(str, 1'b1, 0);
        str = {CHAR_LPAREN, CHAR_RPAREN};
        send_string(str, 1'b0, 0);
        str = {CHAR_LSQ, CHAR_RSQ};
        send_string(str, 1'b1, 0);
        str = {CHAR_LCURL, CHAR_RCURL};
        send_string(str, 1'b0, 0);
        str = {CHAR_LPAREN, CHAR_RSQ};
        send_string(str, 1'b0, 0);
        str = {CHAR_RPAREN, CHAR_LPAREN};
        send_string(str, 1'b0, 0);
        str = {CHAR_LPAREN};
        send_string(str, 1'b0, 0);
        str = {8'h00, 8'h00};
        send_string(str, 1'b0, 0);
        str = {8'hFF};
        send_string(str, 1'b1, 0);
        str = {CHAR_LPAREN, CHAR_LCURL, CHAR_LSQ, CHAR_RSQ, CHAR_RCURL, CHAR_RPAREN};
        send_string(str, 1'b0, 0);
        str = {CHAR_LPAREN, CHAR_RPAREN};
        send_string(str, 1'b0, 100);

        // Random strings, mostly well formed, some damaged or plain noise.
        str_count = 0;
        while (items_sent < TARGET_ITEMS) begin
            str = {};
            pick = $urandom_range(0, 99);
            if (str_count == 3 || str_count == 10 || str_count == 20 || pick < 2)
                kind = STR_DEEP;
            else if (pick < 55)
                kind = STR_NESTED;
            else if (pick < 75)
                kind = STR_DAMAGED;
            else
                kind = STR_JUMBLE;

            case (kind)
                STR_NESTED: begin
                    build_nested($urandom_range(0, 10), str);
                end
                STR_DAMAGED: begin
                    build_nested($urandom_range(1, 8), str);
                    pos = $urandom_range(0, str.size() - 1);
                    str[pos] = $urandom_range(0, 1) ? any_bracket()
                                                    : t_char'($urandom_range(0, 255));
                end
                STR_JUMBLE: begin
                    repeat ($urandom_range(0, 12))
                        str.push_back($urandom_range(0, 1) ? any_bracket()
                                                           : t_char'($urandom_range(0, 255)));
                end
                default: begin
                    if (str_count == 3)
                        build_deep(STACK_DEPTH, str);
                    else if (str_count == 10)
                        build_deep(STACK_DEPTH + 1, str);
                    else if (str_count == 20)
                        build_deep(STACK_DEPTH + 6, str);
                    else
                        build_deep($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4), str);
                end
            endcase

            // The receiver goes quiet for a long while here and the sender
            // keeps offering strings, so the block backs up.
            if (str_count == 5)
                hold_req <= 1'b1;
            if (str_count == 14)
                drain_verdicts();

            send_string(str, $urandom_range(0, 9) < 3, ($urandom_range(0, 3) == 0) ? 15 : 0);
            str_count++;
        end

        drain_verdicts();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        foreach (sb.verdicts_due[i])
            $display("%0t: missing result, expected %b, actual none",
                     $time, sb.verdicts_due[i]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("bracket_balance_checker_top: match");
        end else begin
            $display("bracket_balance_checker_top: mismatch");
        end
        $finish;
    end

endmodule
